// ===== rtl/cbs_pkg.sv =====
// Shared types and constants of the centroid bounding sphere block.
package cbs_pkg;

  localparam int RADIUS_WIDTH = 18;
  localparam int DIST_LIMIT   = 64;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic scan_init;
    logic scan_step;
    logic sqrt_init;
    logic sqrt_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic scan_done;
    logic sqrt_last;
  } sts_t;

endpackage

// ===== rtl/cbs_ctrl.sv =====
// Controller state machine of the centroid bounding sphere block.
module cbs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_set_end,
  input  cbs_pkg::sts_t sts,
  output cbs_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = start;
        if (start && in_set_end) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.sqrt_init = 1'b1;
          state_nxt     = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

`ifndef NO_ASSERTIONS
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == ST_IDLE))
    else $error("load outside idle");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_sqrt_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sqrt_step && sts.sqrt_last) |=> out_valid)
    else $error("square root finished without a result");
`endif

endmodule

// ===== rtl/cbs_dp.sv =====
// Datapath of the centroid bounding sphere block: store, sums, divider, scan, square root.
module cbs_dp #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cbs_pkg::cmd_t                     cmd,
  output cbs_pkg::sts_t                     sts,
  input  logic signed [COORD_WIDTH-1:0]     in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]     in_pos_y,
  input  logic signed [COORD_WIDTH-1:0]     in_pos_z,
  output logic signed [COORD_WIDTH-1:0]     out_center_x,
  output logic signed [COORD_WIDTH-1:0]     out_center_y,
  output logic signed [COORD_WIDTH-1:0]     out_center_z,
  output logic [cbs_pkg::RADIUS_WIDTH-1:0]  out_radius,
  output logic                              out_capacity_exceeded
);

  localparam int CW    = COORD_WIDTH;
  localparam int CNTW  = $clog2(MAX_VERTICES + 1);
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int SW    = CW + CNTW;
  localparam int STPW  = $clog2(SW);
  localparam int DFW   = CW + 1;
  localparam int SQW   = 2 * DFW;
  localparam int DW    = SQW + 2;
  localparam int DISTW = (DW > cbs_pkg::DIST_LIMIT) ? cbs_pkg::DIST_LIMIT : DW;
  localparam int SQI   = DISTW / 2;
  localparam int RMW   = SQI + 2;
  localparam int RW    = cbs_pkg::RADIUS_WIDTH;

  logic [3*CW-1:0] mem [MAX_VERTICES];

  logic signed [SW-1:0] sum_r [3];
  logic [CNTW-1:0]      count_r;
  logic                 ovf_r;
  logic                 full;
  logic signed [CW-1:0] pos [3];
  logic signed [CW-1:0] center [3];

  logic [SW-1:0]        dvd_r [3];
  logic [CNTW-1:0]      rem_r [3];
  logic                 neg_r [3];
  logic [STPW-1:0]      step_r;

  logic [CNTW-1:0]      idx_r;
  logic                 issue;
  logic [3*CW-1:0]      rd_r;
  logic [DFW-1:0]       abs_r [3];
  logic [SQW-1:0]       sq_r [3];
  logic                 v1_r, v2_r, v3_r;
  logic [DW-1:0]        d_full;
  logic [DISTW-1:0]     d_sat;
  logic [DISTW-1:0]     best_r;

  logic [DISTW-1:0]     n_r;
  logic [RMW-1:0]       srem_r;
  logic [SQI-1:0]       root_r;
  logic [RMW+1:0]       cand;
  logic [RMW+1:0]       trial;
  logic                 sq_ge;
  logic [RW+SQI-1:0]    root_ext;

  assign pos[0] = in_pos_x;
  assign pos[1] = in_pos_y;
  assign pos[2] = in_pos_z;
  assign full   = (count_r == CNTW'(MAX_VERTICES));

  // Vertex store.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) mem[count_r[AW-1:0]] <= {in_pos_z, in_pos_y, in_pos_x};
    if (cmd.scan_step && issue) rd_r <= mem[idx_r[AW-1:0]];
  end

  // Per-set sums, count and overflow flag.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      for (int a = 0; a < 3; a++) sum_r[a] <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        for (int a = 0; a < 3; a++) sum_r[a] <= sum_r[a] + SW'(pos[a]);
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Three restoring dividers on the magnitudes, one quotient bit per cycle.
  for (genvar a = 0; a < 3; a++) begin : g_div
    logic [CNTW:0] dtrial;
    logic          dge;
    logic [SW-1:0] qneg;
    assign dtrial = {rem_r[a], dvd_r[a][SW-1]};
    assign dge    = (dtrial >= {1'b0, count_r});
    assign qneg   = SW'(-dvd_r[a]);
    assign center[a] = neg_r[a] ? qneg[CW-1:0] : dvd_r[a][CW-1:0];

    always_ff @(posedge clk) begin
      if (cmd.div_init) begin
        neg_r[a] <= sum_r[a][SW-1];
        dvd_r[a] <= sum_r[a][SW-1] ? SW'(-sum_r[a]) : SW'(sum_r[a]);
        rem_r[a] <= '0;
      end else if (cmd.div_step) begin
        rem_r[a] <= dge ? CNTW'(dtrial - {1'b0, count_r}) : dtrial[CNTW-1:0];
        dvd_r[a] <= {dvd_r[a][SW-2:0], dge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init || cmd.sqrt_init) begin
      step_r <= '0;
    end else if (cmd.div_step || cmd.sqrt_step) begin
      step_r <= step_r + 1'b1;
    end
  end

  // Scan pipeline: read, absolute difference, square, sum and keep the largest.
  assign issue = (idx_r < count_r);

  for (genvar a = 0; a < 3; a++) begin : g_scan
    logic signed [DFW-1:0] diff;
    assign diff = DFW'($signed(rd_r[a*CW +: CW])) - DFW'(center[a]);
    always_ff @(posedge clk) begin
      if (cmd.scan_step) begin
        abs_r[a] <= diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
        sq_r[a]  <= abs_r[a] * abs_r[a];
      end
    end
  end

  assign d_full = DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]);

  if (DW > DISTW) begin : g_sat
    assign d_sat = (|d_full[DW-1:DISTW]) ? '1 : d_full[DISTW-1:0];
  end else begin : g_nosat
    assign d_sat = d_full[DISTW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (cmd.scan_init) begin
      idx_r  <= '0;
      best_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else if (cmd.scan_step) begin
      if (issue) idx_r <= idx_r + 1'b1;
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (v3_r && (d_sat > best_r)) best_r <= d_sat;
    end
  end

  // Digit-by-digit square root, one result bit per cycle.
  assign cand  = {srem_r, n_r[DISTW-1 -: 2]};
  assign trial = (RMW+2)'({root_r, 2'b01});
  assign sq_ge = (cand >= trial);

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      n_r    <= best_r;
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      n_r    <= {n_r[DISTW-3:0], 2'b00};
      srem_r <= sq_ge ? RMW'(cand - trial) : cand[RMW-1:0];
      root_r <= {root_r[SQI-2:0], sq_ge};
    end
  end

  assign root_ext = {{RW{1'b0}}, root_r};

  assign sts.div_last  = (step_r == STPW'(SW - 1));
  assign sts.scan_done = !issue && !v1_r && !v2_r && !v3_r;
  assign sts.sqrt_last = (step_r == STPW'(SQI - 1));

  assign out_center_x          = center[0];
  assign out_center_y          = center[1];
  assign out_center_z          = center[2];
  assign out_radius            = root_ext[RW-1:0];
  assign out_capacity_exceeded = ovf_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(MAX_VERTICES))
    else $error("vertex count beyond capacity");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (count_r == '0) && !ovf_r)
    else $error("per-set state not cleared");
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_init |-> (count_r != '0))
    else $error("scan of an empty set");
`endif

endmodule

// ===== rtl/centroid_bounding_sphere.sv =====
// Top level of the centroid bounding sphere block.
// Vertices arrive one per transaction: one is taken at each rising edge where start is high
// and busy is low, so a set loads at one vertex per cycle. The transaction that carries
// in_set_end closes the set; busy then stays high through a preparation step, the division
// (one quotient bit per cycle, three axes in parallel), the distance scan (one stored vertex
// per cycle through a four-stage pipeline behind the single read port of the vertex store),
// the square root (one bit per cycle, with the squared distance saturating at 64 bits once
// COORD_WIDTH passes 30) and one cycle in which the result is shown. The result sits on the
// out_ ports for exactly that one cycle, marked by out_valid, and the receiver cannot stall
// it. Vertices past MAX_VERTICES are dropped and reported in out_capacity_exceeded; per-set
// sums and counts clear as the result goes out.
module centroid_bounding_sphere #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_WIDTH-1:0]     in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]     in_pos_y,
  input  logic signed [COORD_WIDTH-1:0]     in_pos_z,
  input  logic                              in_set_end,
  output logic                              out_valid,
  output logic signed [COORD_WIDTH-1:0]     out_center_x,
  output logic signed [COORD_WIDTH-1:0]     out_center_y,
  output logic signed [COORD_WIDTH-1:0]     out_center_z,
  output logic [cbs_pkg::RADIUS_WIDTH-1:0]  out_radius,
  output logic                              out_capacity_exceeded
);

  // Commands from the controller and status back from the datapath.
  cbs_pkg::cmd_t cmd;
  cbs_pkg::sts_t sts;

  cbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_set_end (in_set_end),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  // The datapath holds the vertex store, the sums and the iterative units.
  cbs_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_pos_x              (in_pos_x),
    .in_pos_y              (in_pos_y),
    .in_pos_z              (in_pos_z),
    .out_center_x          (out_center_x),
    .out_center_y          (out_center_y),
    .out_center_z          (out_center_z),
    .out_radius            (out_radius),
    .out_capacity_exceeded (out_capacity_exceeded)
  );

endmodule

// ===== test/centroid_bounding_sphere_tb.sv =====
// Self-checking testbench for the centroid bounding sphere block.
module centroid_bounding_sphere_tb;

  localparam int STORE_DEPTH = 1024;
  localparam int CW = 16;
  // The run is stopped with a failure if it ever gets this far.
  localparam int CYCLE_LIMIT = 400000;
  localparam int SET_LATENCY = 60;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic signed [CW-1:0]              cx;
    logic signed [CW-1:0]              cy;
    logic signed [CW-1:0]              cz;
    logic [cbs_pkg::RADIUS_WIDTH-1:0]  radius;
    logic                              dropped;
  } sphere_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [CW-1:0] in_pos_x;
  logic signed [CW-1:0] in_pos_y;
  logic signed [CW-1:0] in_pos_z;
  logic in_set_end;
  logic out_valid;
  logic signed [CW-1:0] out_center_x;
  logic signed [CW-1:0] out_center_y;
  logic signed [CW-1:0] out_center_z;
  logic [cbs_pkg::RADIUS_WIDTH-1:0] out_radius;
  logic out_capacity_exceeded;

  centroid_bounding_sphere uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_pos_x              (in_pos_x),
    .in_pos_y              (in_pos_y),
    .in_pos_z              (in_pos_z),
    .in_set_end            (in_set_end),
    .out_valid             (out_valid),
    .out_center_x          (out_center_x),
    .out_center_y          (out_center_y),
    .out_center_z          (out_center_z),
    .out_radius            (out_radius),
    .out_capacity_exceeded (out_capacity_exceeded)
  );

  // Predictor state: the vertices of the open set, its running sums, the drop flag and the predicted spheres.
  vertex_t     open_set[$];
  longint      sum_x, sum_y, sum_z;
  bit          set_dropped;
  sphere_t     expected_spheres[$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned vertices_sent;
  int unsigned spheres_checked;
  int unsigned drop_sets_checked;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Floor square root, one result bit per pass from the top down.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Closes the open set: centroid truncated toward zero, then the farthest vertex.
  function automatic sphere_t close_set();
    sphere_t         s;
    longint          n, cx, cy, cz, dx, dy, dz;
    longint unsigned farthest, d, root;
    n = open_set.size();
    cx = sum_x / n;
    cy = sum_y / n;
    cz = sum_z / n;
    farthest = 0;
    foreach (open_set[i]) begin
      dx = longint'(open_set[i].x) - cx;
      dy = longint'(open_set[i].y) - cy;
      dz = longint'(open_set[i].z) - cz;
      d = dx * dx + dy * dy + dz * dz;
      if (d > farthest) begin
        farthest = d;
      end
    end
    root = floor_sqrt(farthest);
    s.cx = cx[CW-1:0];
    s.cy = cy[CW-1:0];
    s.cz = cz[CW-1:0];
    s.radius = root[cbs_pkg::RADIUS_WIDTH-1:0];
    s.dropped = set_dropped;
    return s;
  endfunction

  // Updates the predictor with one accepted vertex.
  task automatic absorb_vertex(vertex_t v, bit last);
    if (open_set.size() < STORE_DEPTH) begin
      open_set.push_back(v);
      sum_x += v.x;
      sum_y += v.y;
      sum_z += v.z;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      expected_spheres.push_back(close_set());
      open_set.delete();
      sum_x = 0;
      sum_y = 0;
      sum_z = 0;
      set_dropped = 1'b0;
    end
  endtask

  // Presents one vertex and holds it until the block takes the transaction.
  // Start stays high afterward so that back-to-back vertices need no extra edge.
  task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                             logic signed [CW-1:0] z, bit last);
    vertex_t v;
    v = '{x: x, y: y, z: z};
    @(negedge clk);
    start <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_set_end <= last;
    // Busy only moves on a rising edge, so its value here holds at the next edge.
    while (busy) begin
      @(negedge clk);
    end
    @(posedge clk);
    absorb_vertex(v, last);
    vertices_sent++;
  endtask

  // Drops start for a random stretch: mostly none or short, sometimes long.
  task automatic random_gap();
    int unsigned pick;
    int unsigned cycles;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      return;
    end
    cycles = (pick < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Lowers start and waits until every predicted sphere has been seen.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_spheres.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic signed [CW-1:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      return CW'($urandom());
    end else if (pick < 7) begin
      return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end else begin
      return CW'($urandom_range(0, 511) - 256);
    end
  endfunction

  // Compares one sphere from the block with the oldest prediction.
  always @(posedge clk) begin
    sphere_t want;
    sphere_t got;
    if (rst_n && out_valid) begin
      got = '{cx: out_center_x, cy: out_center_y, cz: out_center_z,
              radius: out_radius, dropped: out_capacity_exceeded};
      if (expected_spheres.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected sphere: center %0d %0d %0d radius %0d dropped %0b",
                   got.cx, got.cy, got.cz, got.radius, got.dropped);
        end
      end else begin
        want = expected_spheres.pop_front();
        spheres_checked++;
        if (want.dropped) begin
          drop_sets_checked++;
        end
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("sphere %0d mismatch: center exp %0d %0d %0d got %0d %0d %0d",
                     spheres_checked, want.cx, want.cy, want.cz, got.cx, got.cy, got.cz);
            $display("  radius exp %0d got %0d, capacity flag exp %0b got %0b",
                     want.radius, got.radius, want.dropped, got.dropped);
          end
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d spheres outstanding",
               cycle_count, expected_spheres.size());
      $display("centroid_bounding_sphere regression: fail");
      $finish;
    end
  end

  // Extremes of every field, one-vertex sets, negative truncation and a random six-vertex set.
  task automatic test_directed();
    send_vertex(16'sh7fff, 16'sh8000, 16'sh0000, 1'b1);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
    // Sums of -3 over two vertices must truncate toward zero, to -1.
    send_vertex(-16'sd1, -16'sd1, 16'sd1, 1'b0);
    send_vertex(-16'sd2, -16'sd2, 16'sd2, 1'b1);
    send_vertex(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_vertex(16'sh5555, 16'shaaaa, 16'sh5555, 1'b0);
    send_vertex(16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0);
    send_vertex(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1);
    drain();
    for (int i = 0; i < 6; i++) begin
      send_vertex(random_coord(), random_coord(), random_coord(), i == 5);
    end
  endtask

  // Fills the store twice: once past capacity with set_end on a dropped vertex and once with a
  // set that ends exactly at capacity, which must not be flagged.
  task automatic test_capacity();
    for (int i = 0; i < STORE_DEPTH + 6; i++) begin
      send_vertex(CW'($urandom()), CW'($urandom()), CW'($urandom()),
                  i == STORE_DEPTH + 5);
    end
    drain();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      send_vertex(CW'($urandom()), CW'($urandom()), CW'($urandom()),
                  i == STORE_DEPTH - 1);
    end
    // The next set must start clean after a full one.
    send_vertex(16'sd256, -16'sd256, 16'sd0, 1'b1);
  endtask

  // Random sets, mostly short, with idle gaps and occasional full drains partway through.
  task automatic test_random();
    int unsigned target;
    int unsigned size;
    target = vertices_sent + 500;
    while (vertices_sent < target) begin
      size = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      for (int i = 0; i < size; i++) begin
        random_gap();
        send_vertex(random_coord(), random_coord(), random_coord(), i == size - 1);
      end
      if ($urandom_range(0, 24) == 0) begin
        drain();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_set_end = 1'b0;
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    set_dropped = 1'b0;
    cycle_count = 0;
    mismatch_count = 0;
    vertices_sent = 0;
    spheres_checked = 0;
    drop_sets_checked = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    drain();
    test_capacity();
    drain();
    test_random();
    drain();
    repeat (SET_LATENCY) @(negedge clk);

    $display("covered %0d vertices and %0d sphere transactions, %0d with dropped vertices",
             vertices_sent, spheres_checked, drop_sets_checked);
    $display("mismatches: %0d", mismatch_count);
    if (mismatch_count == 0 && expected_spheres.size() == 0) begin
      $display("centroid_bounding_sphere regression: pass");
    end else begin
      $display("centroid_bounding_sphere regression: fail");
    end
    $finish;
  end

endmodule
